// ===== hdl/tdp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdp_pkg
// shared types for the trial division prime test core
// ----------------------------------------------------------------------------
package tdp_pkg;

    // status of the serial divider as seen by the sequencer
    typedef struct packed {
        logic done;      // one-cycle pulse, quotient and remainder are final
        logic rem_zero;  // remainder is zero, valid with done
    } tdp_div_stat_t;

    // divisor that every test starts with
    localparam int unsigned FIRST_DIVISOR = 2;

endpackage

// ===== hdl/tdp_serial_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdp_serial_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module tdp_serial_div #(
    parameter int unsigned WIDTH = 32
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  logic [WIDTH-1:0]     dividend,
    input  logic [WIDTH-1:0]     divisor,
    output logic [WIDTH-1:0]     quotient,
    output tdp_pkg::tdp_div_stat_t stat
);
    import tdp_pkg::*;

    localparam int unsigned CNT_W = $clog2(WIDTH + 1);

    logic [WIDTH-1:0] quo_reg, quo_next;   // dividend shifts out, quotient shifts in
    logic [WIDTH-1:0] rem_reg, rem_next;
    logic [WIDTH-1:0] dsr_reg, dsr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;

    logic [WIDTH:0]   trial;
    logic [WIDTH:0]   diff;
    logic             ge;

    always_comb begin
        trial = {rem_reg, quo_reg[WIDTH-1]};
        diff  = trial - {1'b0, dsr_reg};
        ge    = (trial >= {1'b0, dsr_reg});
    end

    always_comb begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            quo_next  = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
            cnt_next  = CNT_W'(WIDTH);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            quo_next = {quo_reg[WIDTH-2:0], ge};
            rem_next = ge ? diff[WIDTH-1:0] : trial[WIDTH-1:0];
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign quotient      = quo_reg;
    assign stat.done     = done_reg;
    assign stat.rem_zero = (rem_reg == '0);

endmodule

// ===== hdl/trial_division_prime_test_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trial_division_prime_test_core
// reports whether a signed word is prime by trial division with d*d <= n
// ----------------------------------------------------------------------------
//  channel  | direction | ports                          | word
//  ---------+-----------+--------------------------------+---------------------
//  s_       | in        | s_valid s_ready s_candidate    | value to test
//  m_       | out       | m_valid m_ready m_is_prime     | 1 if prime, else 0
//
//  one word is tested at a time; the serial divider sets the pace
//  negative, zero and one are answered without dividing
//  otherwise the sequencer tries t trial divisors from 2 upward, where t is
//  floor(sqrt(n)) for a prime and p - 1 for a composite with smallest factor p
//  each trial divisor takes one pass of the divider, started by the start
//  register, and the sequencer then reads its done
//  a stalled result sits in the output register; the next word is taken
//  meanwhile and its verdict waits until the register is free
//  reset is synchronous, active low, and returns the sequencer to idle
// ----------------------------------------------------------------------------
module trial_division_prime_test_core #(
    parameter int unsigned VALUE_WIDTH = 32
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [VALUE_WIDTH-1:0] s_candidate,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_is_prime
);
    import tdp_pkg::*;

    localparam int unsigned W = VALUE_WIDTH;

    // sequencer states
    localparam logic [1:0] ST_IDLE   = 2'd0;  // waiting for a word
    localparam logic [1:0] ST_DIV    = 2'd1;  // trial division running
    localparam logic [1:0] ST_RESULT = 2'd2;  // verdict waits for the output register

    logic [1:0]   state_reg, state_next;
    logic [W-1:0] n_reg, n_next;         // value under test, non-negative once division starts
    logic [W-1:0] d_reg, d_next;         // current trial divisor
    logic         start_reg, start_next; // registered kick for the divider, set with its divisor
    logic         verdict_reg, verdict_next;
    logic         m_valid_reg, m_valid_next;
    logic         m_prime_reg, m_prime_next;

    logic [W-1:0]  quotient;
    tdp_div_stat_t div_stat;

    logic accept;
    logic trivial_no;   // negative, zero or one

    tdp_serial_div #(
        .WIDTH (W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (start_reg),
        .dividend (n_reg),
        .divisor  (d_reg),
        .quotient (quotient),
        .stat     (div_stat)
    );

    assign s_ready    = (state_reg == ST_IDLE);
    assign accept     = s_valid && s_ready;
    // sign bit set, or every bit above the lowest one clear
    assign trivial_no = s_candidate[W-1] || (s_candidate[W-1:1] == '0);

    always_comb begin
        state_next   = state_reg;
        n_next       = n_reg;
        d_next       = d_reg;
        start_next   = 1'b0;
        verdict_next = verdict_reg;
        // output register drains on its own handshake
        m_valid_next = m_valid_reg && !m_ready;
        m_prime_next = m_prime_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    n_next = s_candidate;
                    d_next = W'(FIRST_DIVISOR);
                    if (trivial_no) begin
                        verdict_next = 1'b0;
                        state_next   = ST_RESULT;
                    end else begin
                        start_next = 1'b1;
                        state_next = ST_DIV;
                    end
                end
            end
            ST_DIV: begin
                if (div_stat.done) begin
                    // bound first: d > n/d means no divisor up to sqrt(n) divides n
                    if (d_reg > quotient) begin
                        verdict_next = 1'b1;
                        state_next   = ST_RESULT;
                    end else if (div_stat.rem_zero) begin
                        verdict_next = 1'b0;
                        state_next   = ST_RESULT;
                    end else begin
                        d_next     = d_reg + 1'b1;
                        start_next = 1'b1;
                    end
                end
            end
            ST_RESULT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_prime_next = verdict_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            start_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            start_reg   <= start_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        n_reg       <= n_next;
        d_reg       <= d_next;
        verdict_reg <= verdict_next;
        m_prime_reg <= m_prime_next;
    end

    assign m_valid    = m_valid_reg;
    assign m_is_prime = m_prime_reg;

endmodule

// ===== hdl/tdp_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdp_checker
// port-level assertions for the trial division prime test core
// ----------------------------------------------------------------------------
module tdp_checker #(
    parameter int unsigned VALUE_WIDTH = 32
) (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_valid,
    input logic                          s_ready,
    input logic signed [VALUE_WIDTH-1:0] s_candidate,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic                          m_is_prime
);

    // reset empties the output register
    a_reset_clears_out: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("m_valid high after reset");

    // a stalled verdict holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_is_prime))
        else $error("stalled result changed");

    // a waiting input word holds
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_candidate))
        else $error("waiting input word changed");

    // one word at a time: taking a word makes the core busy
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("s_ready stayed high after accept");

    // the core only goes busy because it took a word
    a_busy_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) && $fell(s_ready) |-> $past(s_valid))
        else $error("s_ready fell without an accepted word");

endmodule

bind trial_division_prime_test_core tdp_checker #(
    .VALUE_WIDTH (VALUE_WIDTH)
) u_tdp_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_valid     (s_valid),
    .s_ready     (s_ready),
    .s_candidate (s_candidate),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_is_prime  (m_is_prime)
);

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for trial_division_prime_test_core: a table of directed
// words, then random words, each verdict compared with a typed verdict or
// with a local trial-division predictor while both handshake sides idle and
// stall at random, save in a last phase with no idling
module tb_top;

    localparam int unsigned VW              = 32;
    localparam int unsigned CLK_HALF_NS     = 6;
    localparam int unsigned RESET_CYCLES    = 12;
    // receiver holds off this long right after reset so the core backs up
    localparam int unsigned HOLD_CYCLES     = 400;
    // random words per phase
    localparam int unsigned WORDS_PER_PHASE = 26;
    // random wide positive words are kept only if the predictor needs at most
    // this many trial divisors for them
    localparam int unsigned TRIAL_CAP       = 150;
    // no handshake for this long means the core is stuck
    localparam int unsigned WATCHDOG_LIMIT  = 50000;
    // quiet cycles after the last verdict, catches stray results
    localparam int unsigned DRAIN_CYCLES    = 64;
    localparam int unsigned MAX_REPORTS     = 10;

    // one row of the directed table; known marks a verdict that is typed in
    typedef struct packed {
        logic signed [VW-1:0] value;
        logic                 known;
        logic                 verdict;
    } directed_row_t;

    // what the result channel owes, oldest first
    typedef struct packed {
        logic signed [VW-1:0] value;
        logic                 verdict;
    } owed_verdict_t;

    localparam int unsigned N_DIRECTED = 22;
    localparam directed_row_t DIRECTED_ROWS [N_DIRECTED] = '{
        // never prime: negative extreme, minus one, minus two, zero, one
        '{32'sh8000_0000, 1'b1, 1'b0},
        '{-32'sd1,        1'b1, 1'b0},
        '{-32'sd2,        1'b1, 1'b0},
        '{32'sd0,         1'b1, 1'b0},
        '{32'sd1,         1'b1, 1'b0},
        // two and three need one trial divisor each, four is the smallest composite
        '{32'sd2,         1'b1, 1'b1},
        '{32'sd3,         1'b1, 1'b1},
        '{32'sd4,         1'b1, 1'b0},
        // large even words, bits 1 to 30 set or bit 30 alone
        '{32'sh7fff_fffe, 1'b1, 1'b0},
        '{32'sh4000_0000, 1'b1, 1'b0},
        // small odd values, most of them squares that sit right on the d*d bound
        '{32'sd5,         1'b0, 1'b0},
        '{32'sd9,         1'b0, 1'b0},
        '{32'sd25,        1'b0, 1'b0},
        '{32'sd49,        1'b0, 1'b0},
        '{32'sd899,       1'b0, 1'b0},
        '{32'sd961,       1'b0, 1'b0},
        '{32'sd63001,     1'b0, 1'b0},
        // primes next to 65536, the longest trial runs in the bench
        '{32'sd65521,     1'b0, 1'b0},
        '{32'sd65537,     1'b0, 1'b0},
        // large odd words with small factors
        '{32'sh7fff_fffd, 1'b0, 1'b0},
        '{32'sh7fff_fffb, 1'b0, 1'b0},
        '{32'sh5555_5555, 1'b0, 1'b0}
    };

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 s_valid;
    logic                 s_ready;
    logic signed [VW-1:0] s_candidate;
    logic                 m_valid;
    logic                 m_ready;
    logic                 m_is_prime;

    owed_verdict_t owed_q[$];
    owed_verdict_t head;
    int unsigned   error_count = 0;
    int unsigned   quiet_cycles = 0;
    int unsigned   tx_idle_pct;
    int unsigned   rx_idle_pct;

    trial_division_prime_test_core #(
        .VALUE_WIDTH(VW)
    ) dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_candidate(s_candidate),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_is_prime (m_is_prime)
    );

    always #(CLK_HALF_NS) aclk = ~aclk;

    // trial division with the bound taken as d <= n / d, so no square is formed
    // trials counts divisors tried, which sets how long the core will take
    function automatic logic prime_verdict(input logic signed [VW-1:0] value,
                                           output int unsigned trials);
        longint unsigned n;
        longint unsigned d;
        trials = 0;
        if (value <= 1)
            return 1'b0;
        n = longint'(value);
        for (d = 2; d <= n / d; d++) begin
            trials++;
            if (n % d == 0)
                return 1'b0;
        end
        return 1'b1;
    endfunction

    // random word: mostly small values, some negatives, and wide positives
    // only when their divisor loop ends within TRIAL_CAP trial divisors
    function automatic logic signed [VW-1:0] pick_candidate();
        logic signed [VW-1:0] value;
        int unsigned          trials;
        int unsigned          pick;
        logic                 verdict;
        pick = $urandom_range(0, 99);
        if (pick < 15) begin
            value = $urandom | 32'h8000_0000;
        end else if (pick < 22) begin
            value = $urandom_range(0, 16);
        end else if (pick < 70) begin
            value = $urandom_range(17, 4096);
        end else if (pick < 85) begin
            do begin
                value   = $urandom_range(4097, 1 << 20);
                verdict = prime_verdict(value, trials);
            end while (trials > TRIAL_CAP);
        end else begin
            do begin
                value   = $urandom & 32'h7fff_ffff;
                verdict = prime_verdict(value, trials);
            end while (trials > TRIAL_CAP);
        end
        return value;
    endfunction

    // offer one word, called and returning at a falling edge
    // known selects the typed verdict over the predictor
    task automatic send_word(input logic signed [VW-1:0] value,
                             input logic known, input logic verdict);
        int unsigned   gap;
        int unsigned   trials;
        owed_verdict_t owed;
        gap = ($urandom_range(0, 99) < tx_idle_pct) ? $urandom_range(1, 4) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid     <= 1'b1;
        s_candidate <= value;
        do @(posedge aclk); while (!s_ready);
        owed.value   = value;
        owed.verdict = known ? verdict : prime_verdict(value, trials);
        owed_q.push_back(owed);
        @(negedge aclk);
    endtask

    // receiver: a long hold-off right after reset fills the core and stalls
    // its input, after that m_ready follows the idling of the current phase
    initial begin
        m_ready = 1'b0;
        wait (aresetn);
        repeat (HOLD_CYCLES) @(negedge aclk);
        forever begin
            m_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
            @(negedge aclk);
        end
    end

    // result check and watchdog, sampled on the rising edge
    always @(posedge aclk) begin
        if (!aresetn) begin
            quiet_cycles <= 0;
        end else begin
            if ((s_valid && s_ready) || (m_valid && m_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no word moved for %0d cycles", quiet_cycles);
                $display("[trial_division_prime_test_core] ERROR");
                $finish;
            end
            if (m_valid && m_ready) begin
                if (owed_q.size() == 0) begin
                    if (error_count < MAX_REPORTS)
                        $display("%0t: verdict %0b with no word outstanding",
                                 $realtime, m_is_prime);
                    error_count++;
                end else begin
                    head = owed_q.pop_front();
                    if (m_is_prime !== head.verdict) begin
                        if (error_count < MAX_REPORTS)
                            $display("%0t: candidate %0d is_prime exp %0b got %0b",
                                     $realtime, head.value, head.verdict, m_is_prime);
                        error_count++;
                    end
                end
            end
        end
    end

    // sender and run control
    initial begin
        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_candidate = '0;
        tx_idle_pct = 28;
        rx_idle_pct = 70;
        repeat (RESET_CYCLES) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed words go out, the first of them while the receiver is still holding off
        foreach (DIRECTED_ROWS[i])
            send_word(DIRECTED_ROWS[i].value, DIRECTED_ROWS[i].known,
                      DIRECTED_ROWS[i].verdict);

        // three phases: receiver mostly idle, sender mostly idle, no idling
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    tx_idle_pct = 28;
                    rx_idle_pct = 70;
                end
                1: begin
                    tx_idle_pct = 70;
                    rx_idle_pct = 28;
                end
                default: begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
            endcase
            repeat (WORDS_PER_PHASE)
                send_word(pick_candidate(), 1'b0, 1'b0);
        end
        s_valid <= 1'b0;

        // every verdict in, then a quiet stretch to catch stray results
        while (owed_q.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (error_count == 0)
            $display("[trial_division_prime_test_core] OK");
        else
            $display("[trial_division_prime_test_core] ERROR");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/tdp_pkg.sv
hdl/tdp_serial_div.sv
hdl/trial_division_prime_test_core.sv
hdl/tdp_checker.sv
test/tb_top.sv
